[rtl/v2d_pkg.sv]
package v2d_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAG_W      = 2 * DATA_WIDTH;
   localparam int REM_W      = DATA_WIDTH + 2;
   localparam int NUM_W      = DATA_WIDTH + FRAC_BITS + 1;
   localparam int LATENCY    = DATA_WIDTH + NUM_W + 5;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic signed [MAG_W-1:0] smag_type;
   typedef logic [MAG_W-1:0] mag_type;

   localparam word_type WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam mag_type  POS_LIM  = {{(MAG_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam mag_type  NEG_LIM  = {{(MAG_W-DATA_WIDTH){1'b0}}, 1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam mag_type  HALF     = {{(MAG_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_SCALE  = 3'd2,
      OP_LENGTH = 3'd3,
      OP_NORM   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      word_type val;
      logic     sat;
   } res_type;

   typedef struct packed {
      logic       vld;
      logic [2:0] op;
      word_type   rx;
      word_type   ry;
      logic       sat;
      word_type   ax;
      word_type   ay;
   } side_type;

   typedef struct packed {
      mag_type          rad;
      logic [REM_W-1:0] rem;
      word_type         root;
   } sqrt_type;

   typedef struct packed {
      word_type         rem;
      logic [NUM_W-1:0] nq;
   } lane_type;

   typedef struct packed {
      word_type den;
      lane_type x;
      lane_type y;
   } div_type;

   function automatic res_type sat_addsub(word_type a, word_type b, logic sub);
      logic [DATA_WIDTH:0] ea;
      logic [DATA_WIDTH:0] eb;
      logic [DATA_WIDTH:0] sum;
      res_type r;
      ea  = {a[DATA_WIDTH-1], a};
      eb  = {b[DATA_WIDTH-1], b};
      sum = sub ? ea - eb : ea + eb;
      r.sat = sum[DATA_WIDTH] ^ sum[DATA_WIDTH-1];
      if (r.sat) begin
         r.val = sum[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      end else begin
         r.val = sum[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic res_type sat_mag(logic neg, mag_type mag);
      res_type r;
      word_type low;
      low = mag[DATA_WIDTH-1:0];
      r.sat = 1'b0;
      if (neg) begin
         if (mag > NEG_LIM) begin
            r.val = WORD_MIN;
            r.sat = 1'b1;
         end else begin
            r.val = word_type'(-low);
         end
      end else begin
         if (mag > POS_LIM) begin
            r.val = WORD_MAX;
            r.sat = 1'b1;
         end else begin
            r.val = low;
         end
      end
      return r;
   endfunction

   function automatic res_type scale_round(smag_type p);
      logic    neg;
      mag_type mag;
      mag_type rnd;
      neg = p[MAG_W-1];
      mag = neg ? mag_type'(-p) : mag_type'(p);
      rnd = (mag + HALF) >> FRAC_BITS;
      return sat_mag(neg, rnd);
   endfunction

   function automatic lane_type div_step(lane_type l, word_type den);
      logic [DATA_WIDTH:0] sh;
      logic [DATA_WIDTH:0] diff;
      logic                ge;
      lane_type            r;
      sh   = {l.rem, l.nq[NUM_W-1]};
      diff = sh - {1'b0, den};
      ge   = sh >= {1'b0, den};
      r.rem = ge ? diff[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
      r.nq  = {l.nq[NUM_W-2:0], ge};
      return r;
   endfunction

endpackage

[rtl/v2d_sqrt_cell.sv]
module v2d_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  v2d_pkg::side_type  up_side,
   input  v2d_pkg::sqrt_type  up_sq,
   output v2d_pkg::side_type  dn_side,
   output v2d_pkg::sqrt_type  dn_sq
);

   v2d_pkg::side_type side_ff;
   v2d_pkg::sqrt_type sq_ff;
   v2d_pkg::sqrt_type sq_in;

   logic [v2d_pkg::REM_W-1:0] rem_sh;
   logic [v2d_pkg::REM_W-1:0] trial;
   logic                      ge;

   always_comb begin
      rem_sh = {up_sq.rem[v2d_pkg::DATA_WIDTH-1:0], up_sq.rad[v2d_pkg::MAG_W-1 -: 2]};
      trial  = {up_sq.root, 2'b01};
      ge     = rem_sh >= trial;
      sq_in.rem  = ge ? rem_sh - trial : rem_sh;
      sq_in.root = {up_sq.root[v2d_pkg::DATA_WIDTH-2:0], ge};
      sq_in.rad  = up_sq.rad << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.vld <= 1'b0;
      end else begin
         side_ff <= up_side;
         sq_ff   <= sq_in;
      end
   end

   assign dn_side = side_ff;
   assign dn_sq   = sq_ff;

endmodule

[rtl/v2d_div_cell.sv]
module v2d_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  v2d_pkg::side_type up_side,
   input  v2d_pkg::div_type  up_div,
   output v2d_pkg::side_type dn_side,
   output v2d_pkg::div_type  dn_div
);

   v2d_pkg::side_type side_ff;
   v2d_pkg::div_type  div_ff;
   v2d_pkg::div_type  div_in;

   always_comb begin
      div_in.den = up_div.den;
      div_in.x   = v2d_pkg::div_step(up_div.x, up_div.den);
      div_in.y   = v2d_pkg::div_step(up_div.y, up_div.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.vld <= 1'b0;
      end else begin
         side_ff <= up_side;
         div_ff  <= div_in;
      end
   end

   assign dn_side = side_ff;
   assign dn_div  = div_ff;

endmodule

[rtl/vector2d_arith_unit_top.sv]
// Signed Q16.16 2D vector unit: add, subtract, scale, length and normalize.
// A request is taken in every cycle (busy stays low) and its result appears
// on the rsp_ports for one cycle with rsp_valid, in request order, for every
// operation alike. The pipeline holds a row of 32 square-root cells (one
// root bit each) followed by a row of 49 divider cells (one quotient bit
// each), plus five stages for products, rounding and the output register.
// The receiver cannot stall the unit.
module vector2d_arith_unit_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [2:0]                              req_type,
   input  logic signed [v2d_pkg::DATA_WIDTH-1:0]   req_a_x,
   input  logic signed [v2d_pkg::DATA_WIDTH-1:0]   req_a_y,
   input  logic signed [v2d_pkg::DATA_WIDTH-1:0]   req_b_x,
   input  logic signed [v2d_pkg::DATA_WIDTH-1:0]   req_b_y,
   input  logic signed [v2d_pkg::DATA_WIDTH-1:0]   req_scalar,
   output logic                                    rsp_valid,
   output logic signed [v2d_pkg::DATA_WIDTH-1:0]   rsp_result_x,
   output logic signed [v2d_pkg::DATA_WIDTH-1:0]   rsp_result_y,
   output logic [v2d_pkg::DATA_WIDTH-1:0]          rsp_length,
   output logic [1:0]                              rsp_status
);

   localparam int DW = v2d_pkg::DATA_WIDTH;
   localparam int NW = v2d_pkg::NUM_W;

   v2d_pkg::side_type s1_side_ff, s1_side_in;
   v2d_pkg::smag_type px_ff, py_ff, sqx_ff, sqy_ff;
   v2d_pkg::smag_type px_in, py_in, sqx_in, sqy_in;
   v2d_pkg::res_type  add_x, add_y;

   v2d_pkg::side_type s2_side_ff, s2_side_in;
   v2d_pkg::sqrt_type s2_sq_ff, s2_sq_in;
   v2d_pkg::res_type  sc_x, sc_y;

   v2d_pkg::side_type sq_side [DW+1];
   v2d_pkg::sqrt_type sq_data [DW+1];

   v2d_pkg::side_type rd_side_ff;
   v2d_pkg::word_type len_ff, len_in;

   v2d_pkg::side_type su_side_ff;
   v2d_pkg::div_type  su_div_ff, su_div_in;
   v2d_pkg::word_type mag_x, mag_y;

   v2d_pkg::side_type dv_side [NW+1];
   v2d_pkg::div_type  dv_data [NW+1];

   v2d_pkg::side_type fin_side;
   v2d_pkg::div_type  fin_div;
   v2d_pkg::res_type  q_x, q_y;

   logic                 rsp_valid_ff;
   v2d_pkg::word_type    rx_ff, rx_in, ry_ff, ry_in, ln_ff, ln_in;
   logic [1:0]           st_ff, st_in;

   assign busy = 1'b0;

   always_comb begin
      add_x = v2d_pkg::sat_addsub(req_a_x, req_b_x, req_type == v2d_pkg::OP_SUB);
      add_y = v2d_pkg::sat_addsub(req_a_y, req_b_y, req_type == v2d_pkg::OP_SUB);
      s1_side_in.vld = start;
      s1_side_in.op  = req_type;
      s1_side_in.rx  = add_x.val;
      s1_side_in.ry  = add_y.val;
      s1_side_in.sat = add_x.sat | add_y.sat;
      s1_side_in.ax  = req_a_x;
      s1_side_in.ay  = req_a_y;
      px_in  = v2d_pkg::smag_type'(req_a_x) * v2d_pkg::smag_type'(req_scalar);
      py_in  = v2d_pkg::smag_type'(req_a_y) * v2d_pkg::smag_type'(req_scalar);
      sqx_in = v2d_pkg::smag_type'(req_a_x) * v2d_pkg::smag_type'(req_a_x);
      sqy_in = v2d_pkg::smag_type'(req_a_y) * v2d_pkg::smag_type'(req_a_y);
   end

   always_comb begin
      sc_x = v2d_pkg::scale_round(px_ff);
      sc_y = v2d_pkg::scale_round(py_ff);
      s2_side_in = s1_side_ff;
      if (s1_side_ff.op == v2d_pkg::OP_SCALE) begin
         s2_side_in.rx  = sc_x.val;
         s2_side_in.ry  = sc_y.val;
         s2_side_in.sat = sc_x.sat | sc_y.sat;
      end
      s2_sq_in.rad  = v2d_pkg::mag_type'(sqx_ff) + v2d_pkg::mag_type'(sqy_ff);
      s2_sq_in.rem  = '0;
      s2_sq_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.vld <= 1'b0;
         s2_side_ff.vld <= 1'b0;
      end else begin
         s1_side_ff <= s1_side_in;
         px_ff      <= px_in;
         py_ff      <= py_in;
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         s2_side_ff <= s2_side_in;
         s2_sq_ff   <= s2_sq_in;
      end
   end

   assign sq_side[0] = s2_side_ff;
   assign sq_data[0] = s2_sq_ff;

   for (genvar k = 0; k < DW; k++) begin : g_sqrt
      v2d_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_side (sq_side[k]),
         .up_sq   (sq_data[k]),
         .dn_side (sq_side[k+1]),
         .dn_sq   (sq_data[k+1])
      );
   end

   always_comb begin
      len_in = sq_data[DW].root
             + v2d_pkg::word_type'(sq_data[DW].rem > {2'b00, sq_data[DW].root});
   end

   always_comb begin
      mag_x = rd_side_ff.ax[DW-1] ? v2d_pkg::word_type'(-rd_side_ff.ax) : rd_side_ff.ax;
      mag_y = rd_side_ff.ay[DW-1] ? v2d_pkg::word_type'(-rd_side_ff.ay) : rd_side_ff.ay;
      su_div_in.den   = len_ff;
      su_div_in.x.rem = '0;
      su_div_in.y.rem = '0;
      su_div_in.x.nq  = NW'({mag_x, {v2d_pkg::FRAC_BITS{1'b0}}}) + NW'(len_ff >> 1);
      su_div_in.y.nq  = NW'({mag_y, {v2d_pkg::FRAC_BITS{1'b0}}}) + NW'(len_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_side_ff.vld <= 1'b0;
         su_side_ff.vld <= 1'b0;
      end else begin
         rd_side_ff <= sq_side[DW];
         len_ff     <= len_in;
         su_side_ff <= rd_side_ff;
         su_div_ff  <= su_div_in;
      end
   end

   assign dv_side[0] = su_side_ff;
   assign dv_data[0] = su_div_ff;

   for (genvar j = 0; j < NW; j++) begin : g_div
      v2d_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_side (dv_side[j]),
         .up_div  (dv_data[j]),
         .dn_side (dv_side[j+1]),
         .dn_div  (dv_data[j+1])
      );
   end

   assign fin_side = dv_side[NW];
   assign fin_div  = dv_data[NW];

   always_comb begin
      q_x = v2d_pkg::sat_mag(fin_side.ax[DW-1], v2d_pkg::mag_type'(fin_div.x.nq));
      q_y = v2d_pkg::sat_mag(fin_side.ay[DW-1], v2d_pkg::mag_type'(fin_div.y.nq));
      rx_in = '0;
      ry_in = '0;
      ln_in = '0;
      st_in = v2d_pkg::ST_OK;
      unique case (fin_side.op)
         v2d_pkg::OP_ADD, v2d_pkg::OP_SUB, v2d_pkg::OP_SCALE: begin
            rx_in = fin_side.rx;
            ry_in = fin_side.ry;
            st_in = fin_side.sat ? v2d_pkg::ST_SAT : v2d_pkg::ST_OK;
         end
         v2d_pkg::OP_LENGTH: begin
            ln_in = fin_div.den;
         end
         v2d_pkg::OP_NORM: begin
            if (fin_div.den == '0) begin
               st_in = v2d_pkg::ST_ZERO;
            end else begin
               rx_in = q_x.val;
               ry_in = q_y.val;
               ln_in = fin_div.den;
               st_in = (q_x.sat | q_y.sat) ? v2d_pkg::ST_SAT : v2d_pkg::ST_OK;
            end
         end
         default: begin
            st_in = v2d_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin_side.vld;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
         ln_ff        <= ln_in;
         st_ff        <= st_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_x = rx_ff;
   assign rsp_result_y = ry_ff;
   assign rsp_length   = ln_ff;
   assign rsp_status   = st_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(v2d_pkg::LATENCY) rsp_valid)
      else $error("request without response");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == v2d_pkg::ST_OK || rsp_status == v2d_pkg::ST_SAT
                     || rsp_status == v2d_pkg::ST_ZERO))
      else $error("bad status");

   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == v2d_pkg::ST_ZERO
      |-> rsp_result_x == '0 && rsp_result_y == '0 && rsp_length == '0)
      else $error("zero vector with nonzero fields");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == v2d_pkg::ST_SAT
      |-> (rsp_result_x == v2d_pkg::WORD_MAX || rsp_result_x == v2d_pkg::WORD_MIN
           || rsp_result_y == v2d_pkg::WORD_MAX || rsp_result_y == v2d_pkg::WORD_MIN))
      else $error("saturation without bound");
`endif

endmodule

[tb/sv/v2d_checker.sv]
`timescale 1ns / 1ps
module v2d_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [2:0]        req_type,
   input  logic [31:0]       req_a_x,
   input  logic [31:0]       req_a_y,
   input  logic [31:0]       req_b_x,
   input  logic [31:0]       req_b_y,
   input  logic [31:0]       req_scalar,
   input  logic              rsp_valid,
   input  logic [31:0]       rsp_result_x,
   input  logic [31:0]       rsp_result_y,
   input  logic [31:0]       rsp_length,
   input  logic [1:0]        rsp_status,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic [31:0] rx;
      logic [31:0] ry;
      logic [31:0] len;
      logic [1:0]  st;
   } vec_result_type;

   vec_result_type result_fifo[$];

   assign pending = result_fifo.size();

   function automatic longint clamp32(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic [63:0] root_rounded(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] x;
      r = 0;
      b = 64'd1 << 62;
      x = s;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (x > r) r = r + 1;
      return r;
   endfunction

   function automatic longint div_half_away(longint num, logic [63:0] den);
      logic [63:0] mag;
      logic [63:0] q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint scale_lane(longint a, longint s);
      longint p;
      logic [63:0] m;
      p = a * s;
      m = p < 0 ? -p : p;
      m = (m + 64'd32768) >> v2d_pkg::FRAC_BITS;
      return p < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic vec_result_type predict_vector(logic [2:0] op, logic [31:0] ax_w,
         logic [31:0] ay_w, logic [31:0] bx_w, logic [31:0] by_w, logic [31:0] sc_w);
      longint ax, ay, bx, by, sc, rx, ry;
      logic [63:0] mx, my, s, len;
      bit sat;
      vec_result_type r;
      ax = longint'(signed'(ax_w));
      ay = longint'(signed'(ay_w));
      bx = longint'(signed'(bx_w));
      by = longint'(signed'(by_w));
      sc = longint'(signed'(sc_w));
      rx = 0;
      ry = 0;
      len = 0;
      sat = 0;
      r.st = v2d_pkg::ST_OK;
      case (op)
         v2d_pkg::OP_ADD: begin
            rx = clamp32(ax + bx, sat);
            ry = clamp32(ay + by, sat);
         end
         v2d_pkg::OP_SUB: begin
            rx = clamp32(ax - bx, sat);
            ry = clamp32(ay - by, sat);
         end
         v2d_pkg::OP_SCALE: begin
            rx = clamp32(scale_lane(ax, sc), sat);
            ry = clamp32(scale_lane(ay, sc), sat);
         end
         v2d_pkg::OP_LENGTH, v2d_pkg::OP_NORM: begin
            mx = ax < 0 ? -ax : ax;
            my = ay < 0 ? -ay : ay;
            s = mx * mx + my * my;
            len = root_rounded(s);
            if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
            if (op == v2d_pkg::OP_NORM) begin
               if (s == 0) begin
                  r.st = v2d_pkg::ST_ZERO;
               end else begin
                  rx = clamp32(div_half_away(ax <<< v2d_pkg::FRAC_BITS, len), sat);
                  ry = clamp32(div_half_away(ay <<< v2d_pkg::FRAC_BITS, len), sat);
               end
            end
         end
         default: ;
      endcase
      if (sat) r.st = v2d_pkg::ST_SAT;
      r.rx = rx[31:0];
      r.ry = ry[31:0];
      r.len = len[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      vec_result_type got;
      vec_result_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy)
            result_fifo.push_back(predict_vector(req_type, req_a_x, req_a_y,
                                                 req_b_x, req_b_y, req_scalar));
         if (rsp_valid) begin
            got = {rsp_result_x, rsp_result_y, rsp_length, rsp_status};
            if (result_fifo.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = result_fifo.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected x=%h y=%h len=%h st=%0d",
                           $time, want.rx, want.ry, want.len, want.st);
                  $display("%0t:          actual   x=%h y=%h len=%h st=%0d",
                           $time, got.rx, got.ry, got.len, got.st);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_type;
   logic [31:0] req_a_x, req_a_y, req_b_x, req_b_y, req_scalar;
   logic        rsp_valid;
   logic [31:0] rsp_result_x, rsp_result_y, rsp_length;
   logic [1:0]  rsp_status;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          idle_pct;

   vector2d_arith_unit_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_a_x(req_a_x), .req_a_y(req_a_y),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_scalar(req_scalar),
      .rsp_valid(rsp_valid), .rsp_result_x(rsp_result_x),
      .rsp_result_y(rsp_result_y), .rsp_length(rsp_length), .rsp_status(rsp_status)
   );

   v2d_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("FAIL vector2d_arith_unit_top");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         6: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic [2:0] op, logic [31:0] ax, logic [31:0] ay,
                               logic [31:0] bx, logic [31:0] by, logic [31:0] sc);
      while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_type <= op;
      req_a_x <= ax;
      req_a_y <= ay;
      req_b_x <= bx;
      req_b_y <= by;
      req_scalar <= sc;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [2:0] op;
      idle_pct = 0;
      reset = 1;
      start = 0;
      req_type = v2d_pkg::OP_ADD;
      req_a_x = 0;
      req_a_y = 0;
      req_b_x = 0;
      req_b_y = 0;
      req_scalar = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_request(v2d_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 0);
      send_request(v2d_pkg::OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h3, 0);
      send_request(v2d_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 0);
      send_request(v2d_pkg::OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h8000_0000, 0);
      send_request(v2d_pkg::OP_SCALE, 32'h0001_8000, 32'hFFFE_8000, 0, 0, 32'h0002_0000);
      send_request(v2d_pkg::OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h8000_0000);
      send_request(v2d_pkg::OP_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 32'h0000_8000);
      send_request(v2d_pkg::OP_SCALE, 32'h0000_0003, 32'h0, 0, 0, 32'hFFFF_8000);
      send_request(v2d_pkg::OP_LENGTH, 32'h0003_0000, 32'h0004_0000, 0, 0, 0);
      send_request(v2d_pkg::OP_LENGTH, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
      send_request(v2d_pkg::OP_LENGTH, 32'h0, 32'h0, 0, 0, 0);
      send_request(v2d_pkg::OP_LENGTH, 32'h7FFF_FFFF, 32'h1, 0, 0, 0);
      send_request(v2d_pkg::OP_NORM, 32'h0, 32'h0, 0, 0, 0);
      send_request(v2d_pkg::OP_NORM, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0);
      send_request(v2d_pkg::OP_NORM, 32'h0000_0001, 32'h0, 0, 0, 0);
      send_request(v2d_pkg::OP_NORM, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      send_request(v2d_pkg::OP_NORM, 32'h0, 32'h8000_0000, 0, 0, 0);
      send_request(3'd5, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5);
      send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
      send_request(3'd7, 0, 0, 0, 0, 0);
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 81 : (ph == 3) ? 18 : 0;
         for (int i = 0; i < 170; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_request(op, pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word());
         end
      end
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (v2d_pkg::LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS vector2d_arith_unit_top");
      end else begin
         $display("FAIL vector2d_arith_unit_top");
      end
      $finish;
   end

endmodule
